[hdl/str_pkg.sv]
package str_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = WORD_W;
  // a 32-bit Q16.16 argument keeps the fixed-point cube root below 2^22
  localparam int CB_BITS   = 22;
  localparam int CUBE_W    = 68;

  localparam logic [WORD_W-1:0] GRAV_RESET = 32'd2818527;
  localparam logic [WORD_W:0]   ONE        = 33'd1 << FRAC_BITS;

  // register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_GRAV = 1'b1;

  // pipeline stage map
  localparam int ST_IN  = 0;
  localparam int ST_SQ  = 1;
  localparam int ST_SUM = 2;
  localparam int ST_D1  = 3;
  localparam int ST_D2  = ST_D1 + DIV_STEPS + 1;
  localparam int ST_D3  = ST_D2 + DIV_STEPS + 1;
  localparam int ST_CB  = ST_D3 + DIV_STEPS + 1;
  localparam int ST_MUL = ST_CB + 2 * CB_BITS + 1;
  localparam int ST_OUT = ST_MUL + 1;

  // one lane of a restoring divider
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] lo;
    logic [63:0] den;
    logic        ovf;
  } div_t;

  typedef struct packed {
    logic              central;
    logic              err;
    logic [31:0]       own;
    logic [31:0]       hr;
    logic [31:0]       hm;
    logic [31:0]       mdm;
    logic [5:0][31:0]  mag;
    logic [5:0][63:0]  sq;
    logic [63:0]       hr2;
    logic [63:0]       ghm;
    logic [63:0]       ssp;
    logic [63:0]       ssv;
    div_t              da;
    div_t              db;
    div_t              dc;
    div_t              dv;
    div_t              dq;
    logic [63:0]       prod;
    logic [63:0]       n;
    logic [CB_BITS-1:0] c;
    logic [43:0]       c2;
    logic [63:0]       c3;
    logic [43:0]       t2;
    logic [CUBE_W-1:0] t3;
    logic [53:0]       pr;
    logic [31:0]       res;
  } item_t;

  // quotient overflows exactly when the upper numerator word reaches the divisor
  function automatic div_t div_init(logic [63:0] nhi, logic [31:0] nlo, logic [63:0] den);
    div_t d;
    d.ovf = (nhi >= den);
    d.rem = nhi;
    d.lo  = nlo;
    d.den = den;
    return d;
  endfunction

  // one quotient bit: shift in the next numerator bit, trial subtract
  function automatic div_t div_step(div_t d);
    div_t        r;
    logic [64:0] t;
    logic        qb;
    r  = d;
    t  = {d.rem, d.lo[31]};
    qb = (t >= {1'b0, d.den});
    if (qb) begin
      r.rem = 64'(t - {1'b0, d.den});
    end else begin
      r.rem = t[63:0];
    end
    r.lo = {d.lo[30:0], qb};
    return r;
  endfunction

  function automatic logic [31:0] div_result(div_t d);
    return d.ovf ? '1 : d.lo;
  endfunction

  function automatic logic [31:0] magnitude(logic [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

endpackage

[hdl/satellite_tidal_radius.sv]
// Tidal radius of a satellite in a singular isothermal sphere host, fully
// pipelined: one request may be issued with start in every cycle (busy stays
// low) and its result appears with done in request order. The pipeline is
// built around three chained 32-stage restoring dividers (mass, position and
// circular-velocity ratios; velocity ratio; final quotient), a 22-bit cube
// root taking two stages per bit, and the closing multiply. The receiver
// cannot stall, so results must be taken as they come. Configuration may only
// be written while no request is in flight.
module satellite_tidal_radius (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_wr,
  input  logic                cfg_idx,
  input  logic [31:0]         cfg_data,
  input  logic                is_central,
  input  logic [31:0]         own_radius,
  input  logic [31:0]         sat_dark_mass,
  input  logic [31:0]         sat_virial_mass,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  vel_x,
  input  logic signed [31:0]  vel_y,
  input  logic signed [31:0]  vel_z,
  input  logic [31:0]         host_radius,
  input  logic [31:0]         host_mass,
  output logic                done,
  output logic [31:0]         tidal_radius,
  output logic                error
);
  import str_pkg::*;

  logic        formula_mode;
  logic [31:0] grav_const;

  logic  vld [0:ST_OUT];
  item_t dat [0:ST_OUT];
  item_t in_item;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      formula_mode <= 1'b0;
      grav_const   <= GRAV_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE: formula_mode <= cfg_data[0];
        REG_GRAV: grav_const   <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture, component magnitudes taken on the way in
  always_comb begin
    in_item         = '0;
    in_item.central = is_central;
    in_item.err     = !is_central && (sat_dark_mass != sat_virial_mass);
    in_item.own     = own_radius;
    in_item.hr      = host_radius;
    in_item.hm      = host_mass;
    in_item.mdm     = sat_dark_mass;
    in_item.mag[0]  = magnitude(pos_x);
    in_item.mag[1]  = magnitude(pos_y);
    in_item.mag[2]  = magnitude(pos_z);
    in_item.mag[3]  = magnitude(vel_x);
    in_item.mag[4]  = magnitude(vel_y);
    in_item.mag[5]  = magnitude(vel_z);
  end

  always_ff @(posedge clk) begin
    vld[ST_IN] <= rst ? 1'b0 : (start && !busy);
    dat[ST_IN] <= in_item;
  end

  for (genvar k = ST_IN + 1; k <= ST_OUT; k++) begin : g_stage
    item_t nx;

    if (k == ST_SQ) begin : g_sq
      // squares and the two products feeding the first divider bank
      always_comb begin
        nx = dat[k-1];
        for (int i = 0; i < 6; i++) begin
          nx.sq[i] = 64'(dat[k-1].mag[i]) * 64'(dat[k-1].mag[i]);
        end
        nx.hr2 = 64'(dat[k-1].hr) * 64'(dat[k-1].hr);
        nx.ghm = 64'(grav_const) * 64'(dat[k-1].hm);
      end
    end else if (k == ST_SUM) begin : g_sum
      always_comb begin
        nx     = dat[k-1];
        nx.ssp = dat[k-1].sq[0] + dat[k-1].sq[1] + dat[k-1].sq[2];
        nx.ssv = dat[k-1].sq[3] + dat[k-1].sq[4] + dat[k-1].sq[5];
      end
    end else if (k == ST_D1) begin : g_d1
      // mass ratio, squared radius ratio, squared circular velocity
      always_comb begin
        nx    = dat[k-1];
        nx.da = div_init(64'(dat[k-1].mdm[31:16]), {dat[k-1].mdm[15:0], 16'h0},
                         64'(dat[k-1].hm));
        nx.db = div_init(64'(dat[k-1].ssp[63:16]), {dat[k-1].ssp[15:0], 16'h0},
                         dat[k-1].hr2);
        nx.dc = div_init(64'(dat[k-1].ghm[63:32]), dat[k-1].ghm[31:0],
                         64'(dat[k-1].hr));
      end
    end else if (k > ST_D1 && k < ST_D2) begin : g_d1s
      always_comb begin
        nx    = dat[k-1];
        nx.da = div_step(dat[k-1].da);
        nx.db = div_step(dat[k-1].db);
        nx.dc = div_step(dat[k-1].dc);
      end
    end else if (k == ST_D2) begin : g_d2
      // squared velocity ratio, and mass ratio times squared radius ratio
      always_comb begin
        nx      = dat[k-1];
        nx.dv   = div_init(64'(dat[k-1].ssv[63:32]), dat[k-1].ssv[31:0],
                           64'(div_result(dat[k-1].dc)));
        nx.prod = 64'(div_result(dat[k-1].da)) * 64'(div_result(dat[k-1].db));
      end
    end else if (k > ST_D2 && k < ST_D3) begin : g_d2s
      always_comb begin
        nx    = dat[k-1];
        nx.dv = div_step(dat[k-1].dv);
      end
    end else if (k == ST_D3) begin : g_d3
      // velocity term only in the second formula mode
      always_comb begin
        nx    = dat[k-1];
        nx.dq = div_init(64'(dat[k-1].prod[63:32]), dat[k-1].prod[31:0],
                         formula_mode ? 64'(ONE + 33'(div_result(dat[k-1].dv)))
                                      : 64'(ONE));
      end
    end else if (k > ST_D3 && k < ST_CB) begin : g_d3s
      always_comb begin
        nx    = dat[k-1];
        nx.dq = div_step(dat[k-1].dq);
      end
    end else if (k == ST_CB) begin : g_cb
      // cube root target is q scaled by two fraction widths
      always_comb begin
        nx    = dat[k-1];
        nx.n  = {div_result(dat[k-1].dq), 32'h0};
        nx.c  = '0;
        nx.c2 = '0;
        nx.c3 = '0;
      end
    end else if (k > ST_CB && k < ST_MUL) begin : g_cube
      localparam int J = k - ST_CB - 1;
      localparam int B = CB_BITS - 1 - J / 2;
      if (J % 2 == 0) begin : g_trial
        // (c + 2^B)^2 and ^3 built from the running square and cube
        always_comb begin
          nx    = dat[k-1];
          nx.t3 = CUBE_W'(dat[k-1].c3)
                + ((CUBE_W'(dat[k-1].c2) + (CUBE_W'(dat[k-1].c2) << 1)) << B)
                + ((CUBE_W'(dat[k-1].c) + (CUBE_W'(dat[k-1].c) << 1)) << (2 * B))
                + (CUBE_W'(1) << (3 * B));
          nx.t2 = 44'(46'(dat[k-1].c2) + (46'(dat[k-1].c) << (B + 1))
                      + (46'(1) << (2 * B)));
        end
      end else begin : g_keep
        always_comb begin
          nx = dat[k-1];
          if (dat[k-1].t3 <= CUBE_W'(dat[k-1].n)) begin
            nx.c  = dat[k-1].c | (CB_BITS'(1) << B);
            nx.c2 = dat[k-1].t2;
            nx.c3 = dat[k-1].t3[63:0];
          end
        end
      end
    end else if (k == ST_MUL) begin : g_mul
      always_comb begin
        nx    = dat[k-1];
        nx.pr = 54'(dat[k-1].hr) * 54'(dat[k-1].c);
      end
    end else begin : g_out
      // saturate and pick the answer for centrals and mass mismatches
      always_comb begin
        nx = dat[k-1];
        if (dat[k-1].central) begin
          nx.res = dat[k-1].own;
        end else if (dat[k-1].err) begin
          nx.res = '0;
        end else if (dat[k-1].pr[53:48] != 6'h0) begin
          nx.res = '1;
        end else begin
          nx.res = dat[k-1].pr[47:16];
        end
      end
    end

    always_ff @(posedge clk) begin
      vld[k] <= rst ? 1'b0 : vld[k-1];
      dat[k] <= nx;
    end
  end

  assign done         = vld[ST_OUT];
  assign tidal_radius = dat[ST_OUT].res;
  assign error        = dat[ST_OUT].err;

endmodule

[tb/satellite_tidal_radius_tb.sv]
module satellite_tidal_radius_tb;
  import str_pkg::*;

  typedef struct {
    logic        central;
    logic [31:0] own;
    logic [31:0] mdm;
    logic [31:0] mvir;
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic [31:0] hr;
    logic [31:0] hm;
  } sat_req_t;

  typedef struct {
    logic [31:0] radius;
    logic        err;
  } radius_res_t;

  // tidal radius predictor and in-order store of expected results
  class radius_board;
    logic        mode;
    logic [31:0] grav;
    radius_res_t pending[$];
    int          fails;
    int          seen;
    int          n_central;
    int          n_mismatch;
    int          n_sat;

    function void reset_regs();
      mode = 1'b0;
      grav = GRAV_RESET;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == REG_MODE) begin
        mode = val[0];
      end else begin
        grav = val;
      end
    endfunction

    // floor(num * 2^sh / den), full scale on zero divisor or overflow
    function logic [31:0] quot(logic [63:0] num, logic [63:0] den, int sh);
      logic [127:0] q;
      if (den == 64'd0) return '1;
      q = ({64'd0, num} << sh) / {64'd0, den};
      return (q > 128'hFFFF_FFFF) ? '1 : q[31:0];
    endfunction

    function logic [63:0] sum_sq(logic [31:0] v [3]);
      logic [63:0] s;
      logic [31:0] m;
      s = 64'd0;
      for (int i = 0; i < 3; i++) begin
        m = v[i][31] ? 32'(-v[i]) : v[i];
        s += {32'd0, m} * {32'd0, m};
      end
      return s;
    endfunction

    // largest c with c^3 <= p * 2^32
    function logic [31:0] cube_root(logic [31:0] p);
      logic [127:0] lim;
      logic [127:0] t;
      logic [31:0]  c;
      lim = {64'd0, p, 32'd0};
      c = 32'd0;
      for (int b = 31; b >= 0; b--) begin
        t = {96'd0, c | (32'd1 << b)};
        if (t * t * t <= lim) c = t[31:0];
      end
      return c;
    endfunction

    function radius_res_t predict(sat_req_t r);
      radius_res_t  o;
      logic [31:0]  msub, x2, vc2, v2, cr;
      logic [63:0]  den;
      logic [127:0] scaled;
      o.radius = 32'd0;
      o.err    = 1'b0;
      if (r.central) begin
        o.radius = r.own;
      end else if (r.mdm != r.mvir) begin
        o.err = 1'b1;
      end else begin
        msub = quot({32'd0, r.mdm}, {32'd0, r.hm}, FRAC_BITS);
        x2   = quot(sum_sq(r.pos), {32'd0, r.hr} * {32'd0, r.hr}, FRAC_BITS);
        vc2  = quot({32'd0, grav} * {32'd0, r.hm}, {32'd0, r.hr}, 0);
        v2   = quot(sum_sq(r.vel), {32'd0, vc2}, 0);
        den  = mode ? (64'd1 << FRAC_BITS) + v2 : (64'd1 << FRAC_BITS);
        cr   = cube_root(quot({32'd0, msub} * {32'd0, x2}, den, 0));
        scaled = ({96'd0, r.hr} * {96'd0, cr}) >> FRAC_BITS;
        o.radius = (scaled > 128'hFFFF_FFFF) ? '1 : scaled[31:0];
      end
      return o;
    endfunction

    function void note_request(sat_req_t r);
      pending.push_back(predict(r));
      if (r.central) n_central++;
      else if (r.mdm != r.mvir) n_mismatch++;
      else n_sat++;
    endfunction

    function void check_result(logic [31:0] radius, logic err);
      radius_res_t w;
      seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result radius=%h error=%b", $time, radius, err);
        fails++;
        return;
      end
      w = pending.pop_front();
      if (radius !== w.radius) begin
        $display("%0t: tidal_radius expected %h actual %h", $time, w.radius, radius);
        fails++;
      end
      if (err !== w.err) begin
        $display("%0t: error expected %b actual %b", $time, w.err, err);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cfg_wr;
  logic        cfg_idx;
  logic [31:0] cfg_data;
  logic        is_central;
  logic [31:0] own_radius;
  logic [31:0] sat_dark_mass;
  logic [31:0] sat_virial_mass;
  logic [31:0] pos_x, pos_y, pos_z;
  logic [31:0] vel_x, vel_y, vel_z;
  logic [31:0] host_radius;
  logic [31:0] host_mass;
  logic        done;
  logic [31:0] tidal_radius;
  logic        error;

  radius_board board;

  satellite_tidal_radius DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_wr(cfg_wr), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .is_central(is_central), .own_radius(own_radius),
    .sat_dark_mass(sat_dark_mass), .sat_virial_mass(sat_virial_mass),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .host_radius(host_radius), .host_mass(host_mass),
    .done(done), .tidal_radius(tidal_radius), .error(error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results cannot be held off: check every strobe
  always @(posedge clk) begin
    if (!rst && done) board.check_result(tidal_radius, error);
  end

  // random value of varied magnitude
  function automatic logic [31:0] spread();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] signed_spread();
    logic [31:0] v;
    v = $urandom_range(0, 7) == 0 ? $urandom : spread();
    return $urandom_range(0, 1) ? 32'(-v) : v;
  endfunction

  function automatic sat_req_t rand_req();
    sat_req_t r;
    int       kind;
    kind = $urandom_range(0, 19);
    r.central = (kind == 0);
    r.own     = $urandom;
    r.mdm     = spread();
    r.mvir    = (kind == 1) ? r.mdm ^ (32'd1 << $urandom_range(0, 31)) : r.mdm;
    if (kind == 2) r.mvir = $urandom;
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = signed_spread();
      r.vel[i] = signed_spread();
    end
    r.hr = spread();
    r.hm = spread();
    return r;
  endfunction

  function automatic sat_req_t fill_req(logic c, logic [31:0] m, logic [31:0] p,
                                        logic [31:0] v, logic [31:0] hr,
                                        logic [31:0] hm);
    sat_req_t r;
    r.central = c;
    r.own     = ~m;
    r.mdm     = m;
    r.mvir    = m;
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = p;
      r.vel[i] = v;
    end
    r.hr = hr;
    r.hm = hm;
    return r;
  endfunction

  // drive one request, hold it until accepted
  task automatic send(sat_req_t r);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    is_central      <= r.central;
    own_radius      <= r.own;
    sat_dark_mass   <= r.mdm;
    sat_virial_mass <= r.mvir;
    pos_x <= r.pos[0];
    pos_y <= r.pos[1];
    pos_z <= r.pos[2];
    vel_x <= r.vel[0];
    vel_y <= r.vel[1];
    vel_z <= r.vel[2];
    host_radius <= r.hr;
    host_mass   <= r.hm;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one write, then release cfg_wr so back-to-back writes never collide
  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_wr   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr <= 1'b0;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic directed();
    sat_req_t r;
    send(fill_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send(fill_req(1'b1, '1, '1, '1, '1, '1));
    send(fill_req(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send(fill_req(1'b0, '1, 32'h8000_0000, 32'h8000_0000, '1, '1));
    send(fill_req(1'b0, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1));
    send(fill_req(1'b0, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'h0010_0000, 32'd0));
    send(fill_req(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'd0,
                  32'h0100_0000));
    send(fill_req(1'b0, 32'h0002_0000, 32'hFFFE_0000, 32'h0003_0000, 32'h0040_0000,
                  32'h0800_0000));
    send(fill_req(1'b0, 32'h0000_0100, 32'h0000_4000, 32'hFFFF_0000, 32'h0008_0000,
                  32'h0010_0000));
    // differing masses, also with all else extreme
    r = fill_req(1'b0, 32'h1234_5678, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'h0001_0000);
    r.mvir = 32'h1234_5679;
    send(r);
    r = fill_req(1'b0, '1, '1, '1, '1, '1);
    r.mvir = 32'd0;
    send(r);
    // central with differing masses gives own radius
    r.central = 1'b1;
    send(r);
  endtask

  initial begin
    logic [31:0] grav_set [5];
    logic        mode_set [5];
    board = new();
    board.reset_regs();
    rst <= 1'b1;
    start <= 1'b0;
    cfg_wr <= 1'b0;
    cfg_idx <= REG_MODE;
    cfg_data <= 32'd0;
    is_central <= 1'b0;
    own_radius <= 32'd0;
    sat_dark_mass <= 32'd0;
    sat_virial_mass <= 32'd0;
    pos_x <= 32'd0; pos_y <= 32'd0; pos_z <= 32'd0;
    vel_x <= 32'd0; vel_y <= 32'd0; vel_z <= 32'd0;
    host_radius <= 32'd0;
    host_mass <= 32'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // settings per phase: reset value, extremes and a random one
    mode_set = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    grav_set = '{GRAV_RESET, GRAV_RESET, 32'd0, '1, $urandom};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(REG_MODE, {31'd0, mode_set[ph]});
        write_reg(REG_GRAV, grav_set[ph]);
      end
      if (ph < 2) directed();
      for (int i = 0; i < 175; i++) send(rand_req());
      drain();
    end
    repeat (160) @(posedge clk);

    if (board.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, board.pending.size());
      board.fails++;
    end
    $display("Covered %0d satellites, %0d centrals, %0d mass mismatches over five",
             board.n_sat, board.n_central, board.n_mismatch);
    $display("mode and constant settings; %0d results checked.", board.seen);
    if (board.fails == 0) begin
      $display("satellite_tidal_radius verification clean");
    end else begin
      $display("satellite_tidal_radius verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("satellite_tidal_radius verification failed");
    $finish;
  end

endmodule

[files.f]
hdl/str_pkg.sv
hdl/satellite_tidal_radius.sv
tb/satellite_tidal_radius_tb.sv
